FILE: design/bea_pkg.sv
// Shared types and codes for the button event auto-repeat block.
package bea_pkg;

  // Kind of one result.
  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_PRESS     = 3'd1,
    EV_RELEASE   = 3'd2,
    EV_LINK_UP   = 3'd3,
    EV_LINK_LOST = 3'd4
  } event_kind_t;

  // Meaning of the action field of a request.
  localparam logic ACT_REPORT = 1'b0;
  localparam logic ACT_TICK   = 1'b1;

  // Configuration register indexes.
  localparam int CFG_IDX_BITS = 3;
  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_HOLD_DELAY = 3'd0;
  localparam cfg_idx_t CFG_REPEAT     = 3'd1;
  localparam cfg_idx_t CFG_WATCHDOG   = 3'd2;
  localparam cfg_idx_t CFG_REP_ENABLE = 3'd3;

  // Register reset values.
  localparam logic [15:0] HOLD_DELAY_RST = 16'd500;
  localparam logic [15:0] REPEAT_RST     = 16'd100;
  localparam logic [15:0] WATCHDOG_RST   = 16'd1000;

endpackage

FILE: design/button_event_autorepeat.sv
// Button event decoder with typematic auto-repeat and a link watchdog.
// Each request starts a walk: a leading step for the link event, then one step per entry of
// the hold-timer RAM, one entry per cycle while the walk is not stalled. A new request is
// accepted as the walk of the previous one issues its last step.
// Results leave at one per cycle; a full output register stalls the walk until it is taken.
// Reset (synchronous, rst_n low): registers take their documented values, all timers stop.
module button_event_autorepeat #(
  parameter int BUTTON_COUNT = 7,
  parameter int TIMER_BITS   = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // Request channel
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_action,
  input  logic [6:0]                 in_button_flags,
  // Result channel
  output logic                       out_valid,
  input  logic                       out_ready,
  output bea_pkg::event_kind_t       out_event_kind,
  output logic [2:0]                 out_button_index,
  output logic                       out_is_repeat,
  output logic                       out_last_event,
  // Configuration write channel
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [bea_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [15:0]                cfg_data
);

  import bea_pkg::*;

  // Address width of the hold-timer RAM and width of the walk step counter.
  // Step 0 is the link step; step k handles button k-1.
  localparam int AW = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
  localparam int SW = $clog2(BUTTON_COUNT + 1);
  localparam logic [SW-1:0] STEP_LAST = SW'(BUTTON_COUNT);

  typedef logic [TIMER_BITS-1:0]   timer_t;
  typedef logic [BUTTON_COUNT-1:0] bmask_t;
  typedef logic [SW-1:0]           step_t;
  typedef logic [AW-1:0]           addr_t;

  localparam timer_t TIMER_ONE = TIMER_BITS'(1);

  // ---------------------------------------------------------------------------
  // Configuration registers. Users write only while idle; the block does not enforce this.
  // ---------------------------------------------------------------------------
  logic [15:0] cfg_hold_r;
  logic [15:0] cfg_repeat_r;
  logic [15:0] cfg_wd_r;
  logic        cfg_en_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_hold_r   <= HOLD_DELAY_RST;
      cfg_repeat_r <= REPEAT_RST;
      cfg_wd_r     <= WATCHDOG_RST;
      cfg_en_r     <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_HOLD_DELAY: cfg_hold_r   <= cfg_data;
        CFG_REPEAT:     cfg_repeat_r <= cfg_data;
        CFG_WATCHDOG:   cfg_wd_r     <= cfg_data;
        CFG_REP_ENABLE: cfg_en_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Timer load values, fitted to the timer width.
  timer_t hold_load;
  timer_t repeat_load;
  timer_t wd_load;

  assign hold_load   = TIMER_BITS'(cfg_hold_r);
  assign repeat_load = TIMER_BITS'(cfg_repeat_r);
  assign wd_load     = TIMER_BITS'(cfg_wd_r);

  // ---------------------------------------------------------------------------
  // Pipeline control. The whole walk moves when the output register can load.
  // ---------------------------------------------------------------------------
  logic out_valid_r;
  logic adv;
  logic in_accept;

  // Walk issue stage (A): item information and the step whose RAM read is issued.
  logic        a_busy_r;
  step_t       a_step_r;
  logic        a_action_r;
  bmask_t      a_mask_r;
  bmask_t      a_rises_r;
  event_kind_t a_link_ev_r;

  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = !a_busy_r || ((a_step_r == STEP_LAST) && adv);
  assign in_accept = in_valid && in_ready;

  // ---------------------------------------------------------------------------
  // Small state held in flip-flops: button history, running timers, watchdog.
  // These are brought up to date when a request is accepted; the walk then
  // only has to deal with the per-button counters in RAM.
  // ---------------------------------------------------------------------------
  bmask_t prev_r;
  bmask_t active_r;
  timer_t wd_cnt_r;
  logic   wd_act_r;
  logic   link_r;
  bmask_t due_r;      // counter of each button is at 1 or 0, so it fires on the next tick

  bmask_t flags;
  bmask_t rises;
  bmask_t falls;
  logic   wd_lost;

  assign flags   = BUTTON_COUNT'(in_button_flags);
  assign rises   = flags & ~prev_r;
  assign falls   = ~flags & prev_r;
  assign wd_lost = wd_act_r && (wd_cnt_r <= TIMER_ONE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r   <= '0;
      active_r <= '0;
      wd_cnt_r <= '0;
      wd_act_r <= 1'b0;
      link_r   <= 1'b0;
    end else if (in_accept) begin
      if (in_action == ACT_REPORT) begin
        // A report reloads the watchdog and brings the link up.
        prev_r   <= flags;
        active_r <= (active_r & ~falls) | rises;
        wd_cnt_r <= wd_load;
        wd_act_r <= 1'b1;
        link_r   <= 1'b1;
      end else if (wd_act_r) begin
        if (wd_lost) begin
          // Link lost: every hold timer stops, but the button history stays.
          wd_cnt_r <= '0;
          wd_act_r <= 1'b0;
          link_r   <= 1'b0;
          active_r <= '0;
        end else begin
          wd_cnt_r <= wd_cnt_r - TIMER_ONE;
        end
      end
    end
  end

  // Issue stage: latch what the walk needs to know about the accepted request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_busy_r <= 1'b0;
      a_step_r <= '0;
    end else if (in_accept) begin
      a_busy_r <= 1'b1;
      a_step_r <= '0;
    end else if (adv && a_busy_r) begin
      if (a_step_r == STEP_LAST) begin
        a_busy_r <= 1'b0;
      end else begin
        a_step_r <= a_step_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      a_action_r <= in_action;
      if (in_action == ACT_REPORT) begin
        a_mask_r    <= rises | falls;
        a_rises_r   <= rises;
        a_link_ev_r <= link_r ? EV_NONE : EV_LINK_UP;
      end else begin
        // For a tick the mask is the set of running timers, none after a link loss.
        a_mask_r    <= wd_lost ? '0 : active_r;
        a_rises_r   <= '0;
        a_link_ev_r <= wd_lost ? EV_LINK_LOST : EV_NONE;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Hold-timer RAM. Read is issued in stage A, data is used and written back
  // in stage B. Should an entry be read in the same cycle as it is written, the
  // written value is forwarded.
  // ---------------------------------------------------------------------------
  logic   ram_we;
  addr_t  ram_waddr;
  timer_t ram_wdata;
  logic   ram_re;
  addr_t  ram_raddr;
  timer_t ram_rdata;
  logic   fwd_r;
  timer_t fwd_data_r;

  assign ram_re    = adv && a_busy_r && (a_step_r != '0);
  assign ram_raddr = AW'(a_step_r - 1'b1);

  bea_ram #(
    .WIDTH (TIMER_BITS),
    .DEPTH (BUTTON_COUNT)
  ) u_hold_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Execute stage (B).
  logic        b_valid_r;
  step_t       b_step_r;
  logic        b_action_r;
  bmask_t      b_mask_r;
  bmask_t      b_rises_r;
  event_kind_t b_link_ev_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      fwd_r     <= 1'b0;
    end else if (adv) begin
      b_valid_r <= a_busy_r;
      fwd_r     <= ram_we && ram_re && (ram_waddr == ram_raddr);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_step_r    <= a_step_r;
      b_action_r  <= a_action_r;
      b_mask_r    <= a_mask_r;
      b_rises_r   <= a_rises_r;
      b_link_ev_r <= a_link_ev_r;
      fwd_data_r  <= ram_wdata;
    end
  end

  logic        b_head;
  addr_t       b_idx;
  timer_t      cur;
  logic        cur_due;
  bmask_t      ev_mask;
  bmask_t      above;
  logic        more;
  logic        b_hit;
  logic        b_emit;
  logic        b_write;
  event_kind_t b_kind;
  logic        b_rep;

  assign b_head  = (b_step_r == '0);
  assign b_idx   = AW'(b_step_r - 1'b1);
  assign cur     = fwd_r ? fwd_data_r : ram_rdata;
  assign cur_due = (cur <= TIMER_ONE);

  // Buttons of this request that give a result. For a tick these are the
  // running timers about to fire; the due bits of buttons not yet visited
  // still describe their counters before this tick.
  assign ev_mask = (b_action_r == ACT_REPORT) ? b_mask_r
                                               : (b_mask_r & due_r & {BUTTON_COUNT{cfg_en_r}});

  // Buttons after the current step.
  always_comb begin
    for (int j = 0; j < BUTTON_COUNT; j++) begin
      above[j] = (SW'(j) >= b_step_r);
    end
  end

  assign more  = |(ev_mask & above);
  assign b_hit = !b_head && b_mask_r[b_idx];

  always_comb begin
    b_emit    = 1'b0;
    b_write   = 1'b0;
    b_kind    = EV_NONE;
    b_rep     = 1'b0;
    ram_wdata = hold_load;
    if (b_head) begin
      // Link event, or the single empty result when nothing else follows.
      b_emit = (b_link_ev_r != EV_NONE) || !more;
      b_kind = b_link_ev_r;
    end else if (b_action_r == ACT_REPORT) begin
      b_emit  = b_hit;
      b_write = b_hit && b_rises_r[b_idx];
      b_kind  = b_rises_r[b_idx] ? EV_PRESS : EV_RELEASE;
    end else begin
      // Running timer: count down, or fire and reload with the repeat interval.
      b_write   = b_hit;
      ram_wdata = cur_due ? repeat_load : (cur - TIMER_ONE);
      b_emit    = b_hit && cur_due && cfg_en_r;
      b_kind    = EV_PRESS;
      b_rep     = 1'b1;
    end
  end

  assign ram_we    = adv && b_valid_r && b_write;
  assign ram_waddr = b_idx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      due_r <= '0;
    end else if (ram_we) begin
      due_r[b_idx] <= (ram_wdata <= TIMER_ONE);
    end
  end

  // ---------------------------------------------------------------------------
  // Output register.
  // ---------------------------------------------------------------------------
  event_kind_t out_kind_r;
  logic [2:0]  out_idx_r;
  logic        out_rep_r;
  logic        out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= b_valid_r && b_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_kind_r <= b_kind;
      out_idx_r  <= b_head ? 3'd0 : 3'(b_idx);
      out_rep_r  <= b_rep;
      out_last_r <= !more;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event_kind   = out_kind_r;
  assign out_button_index = out_idx_r;
  assign out_is_repeat    = out_rep_r;
  assign out_last_event   = out_last_r;

`ifndef SYNTH
  // A repeat flag only ever accompanies a press.
  a_repeat_is_press : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_repeat |-> out_event_kind == EV_PRESS)
    else $error("repeat flag on a result that is not a press");

  // A new request only enters once the walk of the previous one is finishing.
  a_accept_slot : assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |-> !a_busy_r || (a_step_r == STEP_LAST))
    else $error("request accepted in the middle of a walk");

  // The link comes up only through an accepted report.
  a_link_rise : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(link_r) |-> $past(in_accept && (in_action == ACT_REPORT)))
    else $error("link came up without a report");

  // The RAM is never written while the walk is stalled.
  a_no_write_stalled : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !ram_we)
    else $error("hold timer written during a stall");

  // The link step always comes first: a link event never follows a button event.
  a_link_first : assert property (@(posedge clk) disable iff (!rst_n)
    adv && b_valid_r && !b_head |-> (b_kind == EV_PRESS) || (b_kind == EV_RELEASE))
    else $error("button step produced a non-button event kind");
`endif

endmodule

FILE: design/bea_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module bea_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

FILE: dv/tb_button_event_autorepeat.sv
// Self-checking testbench for the button event auto-repeat block.
module tb_button_event_autorepeat;
  timeunit 1ns;
  timeprecision 1ps;

  import bea_pkg::*;

  // Register indexes past the last real register; writes to them must be ignored.
  localparam cfg_idx_t CFG_UNUSED_LO = 3'd4;
  localparam cfg_idx_t CFG_UNUSED_HI = 3'd7;

  localparam int BUTTONS          = 7;
  // Cycles without any handshake, while work is pending, before the run is abandoned.
  // The slowest correct case is the long receiver hold-off below, so this is ample.
  localparam int IDLE_LIMIT       = 3000;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int PHASES           = 8;
  localparam int ITEMS_PER_PHASE  = 44;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_action;
  logic [6:0]           in_button_flags;
  logic                 out_valid;
  logic                 out_ready;
  event_kind_t          out_event_kind;
  logic [2:0]           out_button_index;
  logic                 out_is_repeat;
  logic                 out_last_event;
  logic                 cfg_valid;
  logic                 cfg_ready;
  cfg_idx_t             cfg_index;
  logic [15:0]          cfg_data;

  button_event_autorepeat dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_button_flags  (in_button_flags),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_event_kind   (out_event_kind),
    .out_button_index (out_button_index),
    .out_is_repeat    (out_is_repeat),
    .out_last_event   (out_last_event),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // One result as the block presents it.
  typedef struct packed {
    event_kind_t kind;
    logic [2:0]  button;
    logic        is_rep;
    logic        last;
  } key_event_t;

  // Directed stimulus: either a request or a register write. Where a row is marked
  // as typed, its single result is written out here rather than taken from the predictor.
  typedef enum logic {ROW_REQUEST, ROW_CONFIG} row_op_t;

  typedef struct {
    row_op_t     op;
    logic        act;
    logic [15:0] value;
    cfg_idx_t    reg_idx;
    bit          typed;
    event_kind_t kind;
  } stim_row_t;

  stim_row_t directed_rows[] = '{
    // A tick before any report: the watchdog is not yet running, so nothing happens.
    '{ROW_REQUEST, ACT_TICK,   16'h0000, CFG_HOLD_DELAY, 1'b1, EV_NONE},
    // The first report brings the link up and, with no buttons down, nothing more.
    '{ROW_REQUEST, ACT_REPORT, 16'h0000, CFG_HOLD_DELAY, 1'b1, EV_LINK_UP},
    '{ROW_REQUEST, ACT_REPORT, 16'h0000, CFG_HOLD_DELAY, 1'b1, EV_NONE},
    // A zero hold delay behaves as one tick; out-of-range indexes must change nothing.
    '{ROW_CONFIG,  ACT_REPORT, 16'h0000, CFG_HOLD_DELAY, 1'b0, EV_NONE},
    '{ROW_CONFIG,  ACT_REPORT, 16'h0002, CFG_REPEAT,     1'b0, EV_NONE},
    '{ROW_CONFIG,  ACT_REPORT, 16'h0006, CFG_WATCHDOG,   1'b0, EV_NONE},
    '{ROW_CONFIG,  ACT_REPORT, 16'hFFFF, CFG_UNUSED_LO,  1'b0, EV_NONE},
    '{ROW_CONFIG,  ACT_REPORT, 16'h0000, CFG_UNUSED_HI,  1'b0, EV_NONE},
    // Every button pressed at once, then repeats from all seven timers.
    '{ROW_REQUEST, ACT_REPORT, 16'h007F, CFG_HOLD_DELAY, 1'b0, EV_NONE},
    '{ROW_REQUEST, ACT_TICK,   16'h007F, CFG_HOLD_DELAY, 1'b0, EV_NONE},
    '{ROW_REQUEST, ACT_TICK,   16'h0000, CFG_HOLD_DELAY, 1'b0, EV_NONE},
    '{ROW_REQUEST, ACT_TICK,   16'h0055, CFG_HOLD_DELAY, 1'b0, EV_NONE},
    '{ROW_REQUEST, ACT_REPORT, 16'h0055, CFG_HOLD_DELAY, 1'b0, EV_NONE},
    // With repeats switched off the timers still expire and reload, silently.
    '{ROW_CONFIG,  ACT_REPORT, 16'h0000, CFG_REP_ENABLE, 1'b0, EV_NONE},
    '{ROW_REQUEST, ACT_TICK,   16'h0000, CFG_HOLD_DELAY, 1'b0, EV_NONE},
    '{ROW_REQUEST, ACT_TICK,   16'h0000, CFG_HOLD_DELAY, 1'b0, EV_NONE},
    '{ROW_CONFIG,  ACT_REPORT, 16'hFFFF, CFG_REP_ENABLE, 1'b0, EV_NONE},
    // Ticks without a report until the watchdog lapses and the link is lost.
    '{ROW_REQUEST, ACT_TICK,   16'h0000, CFG_HOLD_DELAY, 1'b0, EV_NONE},
    '{ROW_REQUEST, ACT_TICK,   16'h0000, CFG_HOLD_DELAY, 1'b0, EV_NONE},
    '{ROW_REQUEST, ACT_TICK,   16'h0000, CFG_HOLD_DELAY, 1'b0, EV_NONE},
    '{ROW_REQUEST, ACT_TICK,   16'h0000, CFG_HOLD_DELAY, 1'b0, EV_NONE},
    '{ROW_REQUEST, ACT_TICK,   16'h0000, CFG_HOLD_DELAY, 1'b0, EV_NONE},
    // Reconnect with the same buttons held: link-up only, then one release and re-press.
    '{ROW_REQUEST, ACT_REPORT, 16'h0055, CFG_HOLD_DELAY, 1'b0, EV_NONE},
    '{ROW_REQUEST, ACT_REPORT, 16'h0054, CFG_HOLD_DELAY, 1'b0, EV_NONE},
    '{ROW_REQUEST, ACT_REPORT, 16'h0055, CFG_HOLD_DELAY, 1'b0, EV_NONE},
    // Largest register values, then edges on the first and last buttons alone.
    '{ROW_CONFIG,  ACT_REPORT, 16'hFFFF, CFG_HOLD_DELAY, 1'b0, EV_NONE},
    '{ROW_CONFIG,  ACT_REPORT, 16'hFFFF, CFG_REPEAT,     1'b0, EV_NONE},
    '{ROW_CONFIG,  ACT_REPORT, 16'hFFFF, CFG_WATCHDOG,   1'b0, EV_NONE},
    '{ROW_REQUEST, ACT_TICK,   16'h0000, CFG_HOLD_DELAY, 1'b0, EV_NONE},
    '{ROW_REQUEST, ACT_REPORT, 16'h0000, CFG_HOLD_DELAY, 1'b0, EV_NONE},
    '{ROW_REQUEST, ACT_REPORT, 16'h0040, CFG_HOLD_DELAY, 1'b0, EV_NONE},
    '{ROW_REQUEST, ACT_REPORT, 16'h0001, CFG_HOLD_DELAY, 1'b0, EV_NONE}
  };

  // Predictor copy of the registers.
  logic [15:0] hold_delay_reg;
  logic [15:0] repeat_reg;
  logic [15:0] watchdog_reg;
  logic        repeat_on;

  // Predictor copy of the block's state.
  logic [6:0]  prev_flags;
  logic [15:0] hold_count [BUTTONS];
  logic [6:0]  hold_running;
  logic [15:0] wd_count;
  logic        wd_running;
  logic        link_is_up;

  key_event_t  step_events[$];     // results of the request just predicted
  key_event_t  awaited_events[$];  // results still owed by the block

  int gap_pct;
  int stall_pct;
  bit long_hold_req;
  int fail_count;
  int requests_sent;
  int results_seen;
  int repeats_seen;
  int losses_seen;
  int settings_used;
  int idle_cycles;

  function automatic key_event_t make_event(event_kind_t kind, int button, logic is_rep);
    key_event_t ev;
    ev.kind   = kind;
    ev.button = button[2:0];
    ev.is_rep = is_rep;
    ev.last   = 1'b0;
    return ev;
  endfunction

  task automatic reset_model();
    hold_delay_reg = HOLD_DELAY_RST;
    repeat_reg     = REPEAT_RST;
    watchdog_reg   = WATCHDOG_RST;
    repeat_on      = 1'b1;
    prev_flags     = '0;
    hold_running   = '0;
    wd_count       = '0;
    wd_running     = 1'b0;
    link_is_up     = 1'b0;
    for (int i = 0; i < BUTTONS; i++) begin
      hold_count[i] = '0;
    end
  endtask

  function automatic void update_registers(cfg_idx_t idx, logic [15:0] data);
    case (idx)
      CFG_HOLD_DELAY: hold_delay_reg = data;
      CFG_REPEAT:     repeat_reg     = data;
      CFG_WATCHDOG:   watchdog_reg   = data;
      CFG_REP_ENABLE: repeat_on      = data[0];
      default: ;
    endcase
  endfunction

  // Works out every result one request causes and leaves them in step_events.
  // A timer loaded with N fires on the Nth tick; a load of zero fires on the first.
  function automatic void predict_events(logic act, logic [6:0] flags);
    bit lost;
    bit expired;
    lost = 1'b0;
    step_events.delete();
    if (act == ACT_REPORT) begin
      wd_count   = watchdog_reg;
      wd_running = 1'b1;
      if (!link_is_up) begin
        link_is_up = 1'b1;
        step_events.push_back(make_event(EV_LINK_UP, 0, 1'b0));
      end
      for (int i = 0; i < BUTTONS; i++) begin
        if (!flags[i] && prev_flags[i]) begin
          hold_running[i] = 1'b0;
          step_events.push_back(make_event(EV_RELEASE, i, 1'b0));
        end else if (flags[i] && !prev_flags[i]) begin
          hold_count[i]   = hold_delay_reg;
          hold_running[i] = 1'b1;
          step_events.push_back(make_event(EV_PRESS, i, 1'b0));
        end
      end
      prev_flags = flags;
    end else begin
      if (wd_running) begin
        expired  = (wd_count <= 16'd1);
        wd_count = expired ? 16'd0 : wd_count - 16'd1;
        if (expired) begin
          // Link loss stops every hold timer but keeps the last button picture.
          wd_running   = 1'b0;
          link_is_up   = 1'b0;
          hold_running = '0;
          lost         = 1'b1;
          step_events.push_back(make_event(EV_LINK_LOST, 0, 1'b0));
        end
      end
      if (!lost) begin
        for (int i = 0; i < BUTTONS; i++) begin
          if (hold_running[i]) begin
            expired       = (hold_count[i] <= 16'd1);
            hold_count[i] = expired ? 16'd0 : hold_count[i] - 16'd1;
            if (expired) begin
              if (repeat_on) begin
                step_events.push_back(make_event(EV_PRESS, i, 1'b1));
              end
              hold_count[i] = repeat_reg;
            end
          end
        end
      end
    end
    if (step_events.size() == 0) begin
      step_events.push_back(make_event(EV_NONE, 0, 1'b0));
    end
    step_events[step_events.size() - 1].last = 1'b1;
  endfunction

  // Offers one request, after an optional idle burst, and predicts its results once
  // the block has taken it. A typed row supplies its single result directly.
  task automatic send_request(logic act, logic [6:0] flags, bit typed = 1'b0,
                              event_kind_t typed_kind = EV_NONE);
    int gap;
    key_event_t ev;
    @(negedge clk);
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 11);
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_action       <= act;
    in_button_flags <= flags;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    requests_sent++;
    predict_events(act, flags);
    if (typed) begin
      ev      = make_event(typed_kind, 0, 1'b0);
      ev.last = 1'b1;
      awaited_events.push_back(ev);
    end else begin
      foreach (step_events[i]) awaited_events.push_back(step_events[i]);
    end
  endtask

  // Stops offering requests and lets every owed result arrive, and the walk behind
  // the last one run to its end, before registers change.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_events.size() != 0) @(posedge clk);
    repeat (BUTTONS + 4) @(posedge clk);
  endtask

  task automatic write_register(cfg_idx_t idx, logic [15:0] data);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    update_registers(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_setting(logic [15:0] hold, logic [15:0] rep, logic [15:0] wd,
                               logic enable);
    write_register(CFG_HOLD_DELAY, hold);
    write_register(CFG_REPEAT, rep);
    write_register(CFG_WATCHDOG, wd);
    write_register(CFG_REP_ENABLE, {15'd0, enable});
    settings_used++;
  endtask

  // Mostly well-formed traffic: a report that moves one button, or now and then a
  // fresh picture, followed by a short run of ticks. Longer tick runs let the
  // watchdog lapse, and a few requests are pure noise.
  task automatic random_items(int count);
    int sent;
    int run_len;
    int pick;
    logic [6:0] flags;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        send_request(1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)));
        sent++;
      end else if (pick <= 2) begin
        run_len = $urandom_range(1, 24);
        if (run_len > count - sent) run_len = count - sent;
        repeat (run_len) begin
          send_request(ACT_TICK, 7'($urandom_range(0, 127)));
          sent++;
        end
      end else begin
        flags = prev_flags;
        if ($urandom_range(0, 3) == 0) begin
          flags = 7'($urandom_range(0, 127));
        end else begin
          flags[3'($urandom_range(0, BUTTONS - 1))] ^= 1'b1;
        end
        send_request(ACT_REPORT, flags);
        sent++;
        run_len = $urandom_range(0, 6);
        if (run_len > count - sent) run_len = count - sent;
        repeat (run_len) begin
          send_request(ACT_TICK, 7'($urandom_range(0, 127)));
          sent++;
        end
      end
    end
  endtask

  // Result receiver: random stall bursts, and once a long hold-off while requests keep
  // coming, so that the block backs up and has to refuse further requests.
  initial begin : result_sink
    int burst;
    out_ready = 1'b1;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        out_ready <= 1'b1;
        long_hold_req = 1'b0;
      end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
        out_ready <= 1'b0;
        burst = $urandom_range(1, 11);
        repeat (burst) @(negedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  // Each result taken is compared with the oldest one owed.
  always @(posedge clk) begin : check_results
    key_event_t ev;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (awaited_events.size() == 0) begin
        $error("unexpected result: kind %0d button %0d", out_event_kind, out_button_index);
        fail_count++;
      end else begin
        ev = awaited_events.pop_front();
        if (out_event_kind !== ev.kind) begin
          $error("event_kind: expected %0d, got %0d", ev.kind, out_event_kind);
          fail_count++;
        end
        if (out_button_index !== ev.button) begin
          $error("button_index: expected %0d, got %0d", ev.button, out_button_index);
          fail_count++;
        end
        if (out_is_repeat !== ev.is_rep) begin
          $error("is_repeat: expected %0d, got %0d", ev.is_rep, out_is_repeat);
          fail_count++;
        end
        if (out_last_event !== ev.last) begin
          $error("last_event: expected %0d, got %0d", ev.last, out_last_event);
          fail_count++;
        end
        if (ev.kind == EV_PRESS && ev.is_rep) repeats_seen++;
        if (ev.kind == EV_LINK_LOST) losses_seen++;
      end
    end
  end

  // Hang detection: counts cycles with work pending but no handshake on any channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
        || !rst_n) begin
      idle_cycles = 0;
    end else if (awaited_events.size() != 0 || in_valid || cfg_valid) begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no progress for %0d cycles", IDLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : main_sequence
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_action       = ACT_REPORT;
    in_button_flags = '0;
    cfg_valid       = 1'b0;
    cfg_index       = CFG_HOLD_DELAY;
    cfg_data        = '0;
    gap_pct         = 20;
    stall_pct       = 20;
    long_hold_req   = 1'b0;
    fail_count      = 0;
    requests_sent   = 0;
    results_seen    = 0;
    repeats_seen    = 0;
    losses_seen     = 0;
    settings_used   = 1;
    idle_cycles     = 0;
    reset_model();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: walks the table, register writes waiting for the block to go idle.
    foreach (directed_rows[r]) begin
      if (directed_rows[r].op == ROW_CONFIG) begin
        write_register(directed_rows[r].reg_idx, directed_rows[r].value);
      end else begin
        send_request(directed_rows[r].act, directed_rows[r].value[6:0],
                     directed_rows[r].typed, directed_rows[r].kind);
      end
    end
    settings_used += 2;

    // Random part: one register setting per phase, the extremes among them.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: apply_setting(16'd1, 16'd1, 16'd1, 1'b1);        // watchdog lapses on every tick
        1: apply_setting(16'd0, 16'd0, 16'd0, 1'b0);        // zero loads act as one tick
        3: apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        default: begin
          apply_setting(16'($urandom_range(1, 6)), 16'($urandom_range(1, 4)),
                        16'($urandom_range(3, 30)), $urandom_range(0, 3) != 0);
          write_register(cfg_idx_t'($urandom_range(CFG_UNUSED_LO, CFG_UNUSED_HI)),
                         16'($urandom_range(0, 16'hFFFF)));
        end
      endcase
      case ($urandom_range(0, 2))
        0: gap_pct = 0;
        1: gap_pct = 10;
        default: gap_pct = 30;
      endcase
      stall_pct = $urandom_range(0, 1) ? 25 : 5;
      if (p == 2) begin
        // Back-to-back requests against a receiver that has stopped taking results.
        gap_pct       = 0;
        long_hold_req = 1'b1;
      end
      if (p == PHASES - 1) begin
        gap_pct   = 0;
        stall_pct = 0;
      end
      random_items(ITEMS_PER_PHASE);
    end

    drain();
    repeat (20) @(posedge clk);

    $display("Covered %0d requests and %0d results over %0d register settings,",
             requests_sent, results_seen, settings_used);
    $display("including %0d auto-repeat presses and %0d link losses.",
             repeats_seen, losses_seen);
    if (fail_count == 0 && awaited_events.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
